/* src/vrc_pkg.sv */
// ---------------------------------------------------------------------------
// vrc_pkg
// Shared constants, codes and types of the voxel ray caster.
// ---------------------------------------------------------------------------
package vrc_pkg;

   // default grid size
   localparam int GRID_X_DEF = 64;
   localparam int GRID_Y_DEF = 64;
   localparam int GRID_Z_DEF = 64;

   // field widths
   localparam int ORG_W    = 16;
   localparam int DIR_W    = 16;
   localparam int TAG_W    = 20;
   localparam int KIND_W   = 2;
   localparam int CELL_W   = 6;
   localparam int COLOR_W  = 8;
   localparam int CSR_IDX_W = 2;

   // boundary time: unsigned, 16 fraction bits, saturates at 2^62
   localparam int TIME_W = 63;
   localparam logic [TIME_W-1:0] T_SAT = {1'b1, {(TIME_W-1){1'b0}}};

   // reciprocal 2^30 / |d|
   localparam int MAG_W = 16;
   localparam int QUO_W = 31;
   localparam int FRAC_W = 9;

   // codes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_CAST  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Z = 2'd2;

   localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd0;
   localparam logic [KIND_W-1:0] KIND_GRASS = 2'd1;

   localparam logic [COLOR_W-1:0] COLOR_MAX = 8'hFF;
   localparam logic [COLOR_W-1:0] COLOR_OFF = 8'h00;

   // divider request and status
   typedef struct packed {
      logic             start;
      logic [MAG_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [QUO_W-1:0] quotient;
   } div_sts_type;

endpackage

/* src/vrc_if.sv */
// ---------------------------------------------------------------------------
// vrc_req_if / vrc_rsp_if
// Valid/ready channels for request and response transactions.
// ---------------------------------------------------------------------------
interface vrc_req_if;
   logic                         valid;
   logic                         ready;
   logic                         opcode;
   logic [vrc_pkg::CELL_W-1:0]   cell_x;
   logic [vrc_pkg::CELL_W-1:0]   cell_y;
   logic [vrc_pkg::CELL_W-1:0]   cell_z;
   logic [vrc_pkg::KIND_W-1:0]   cell_kind;
   logic signed [vrc_pkg::DIR_W-1:0] ray_dx;
   logic signed [vrc_pkg::DIR_W-1:0] ray_dy;
   logic signed [vrc_pkg::DIR_W-1:0] ray_dz;
   logic [vrc_pkg::TAG_W-1:0]    pixel_tag;

   modport source (output valid, opcode, cell_x, cell_y, cell_z, cell_kind,
                   ray_dx, ray_dy, ray_dz, pixel_tag, input ready);
   modport sink   (input valid, opcode, cell_x, cell_y, cell_z, cell_kind,
                   ray_dx, ray_dy, ray_dz, pixel_tag, output ready);
endinterface

interface vrc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [vrc_pkg::TAG_W-1:0]     tag_out;
   logic [vrc_pkg::COLOR_W-1:0]   red;
   logic [vrc_pkg::COLOR_W-1:0]   green;
   logic [vrc_pkg::COLOR_W-1:0]   blue;
   logic                          hit;
   logic [vrc_pkg::KIND_W-1:0]    hit_kind;

   modport source (output valid, tag_out, red, green, blue, hit, hit_kind, input ready);
   modport sink   (input valid, tag_out, red, green, blue, hit, hit_kind, output ready);
endinterface

/* src/vrc_recip_div.sv */
// ---------------------------------------------------------------------------
// vrc_recip_div
// Restoring divider, one quotient bit per cycle, computes 2^30 / divisor.
// ---------------------------------------------------------------------------
module vrc_recip_div (
   input  logic                 clock,
   input  logic                 reset,
   input  vrc_pkg::div_req_type div_req,
   output vrc_pkg::div_sts_type div_sts
);
   localparam int CNT_W = $clog2(vrc_pkg::QUO_W);

   logic [vrc_pkg::MAG_W:0]   rem_ff, rem_in;
   logic [vrc_pkg::QUO_W-1:0] quo_ff, quo_in;
   logic [vrc_pkg::MAG_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [vrc_pkg::MAG_W:0]   shifted;

   // the dividend has a single one at its top bit
   always_comb begin
      shifted = {rem_ff[vrc_pkg::MAG_W-1:0], (cnt_ff == '0)};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start && !busy_ff) begin
         rem_in  = '0;
         quo_in  = '0;
         dvs_in  = div_req.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // subtract when the partial remainder covers the divisor
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_in = shifted - {1'b0, dvs_ff};
            quo_in = {quo_ff[vrc_pkg::QUO_W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[vrc_pkg::QUO_W-2:0], 1'b0};
         end
         if (cnt_ff == CNT_W'(vrc_pkg::QUO_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_sts.busy     = busy_ff;
   assign div_sts.done     = done_ff;
   assign div_sts.quotient = quo_ff;
endmodule

/* src/vrc_grid_mem.sv */
// ---------------------------------------------------------------------------
// vrc_grid_mem
// Voxel type store: one write port, one registered read port.
// ---------------------------------------------------------------------------
module vrc_grid_mem #(
   parameter int DEPTH  = vrc_pkg::GRID_X_DEF * vrc_pkg::GRID_Y_DEF * vrc_pkg::GRID_Z_DEF,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [vrc_pkg::KIND_W-1:0]  wr_data,
   input  logic [ADDR_W-1:0]           rd_addr,
   output logic [vrc_pkg::KIND_W-1:0]  rd_data
);
   logic [vrc_pkg::KIND_W-1:0] mem [DEPTH];
   logic [vrc_pkg::KIND_W-1:0] rd_ff;

   // write when enabled, read every cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   assign rd_data = rd_ff;
endmodule

/* src/voxel_ray_dda_caster_top.sv */
// ---------------------------------------------------------------------------
// voxel_ray_dda_caster_top
// Voxel grid store and 3-D DDA ray walker with one response per cast.
// ---------------------------------------------------------------------------
// After reset the block clears the grid, one voxel a cycle, and it accepts
// no request until the clear is through. Origin writes are taken at any time.
// A cast is set up axis by axis. A nonzero direction axis starts the shared
// bit-serial reciprocal divider, waits for it and takes the quotient, then
// does the first-boundary multiply. A zero axis skips the divider.
// The walk then does one start check and, for each voxel step that stays
// inside the grid, a step and then a grid read. The step that leaves the
// grid ends the walk. The response is then posted.
// The response sits in an output register, so the next request is taken
// while it waits. A cast that finishes while the previous response is
// still held waits until that response is taken.
// ---------------------------------------------------------------------------
module voxel_ray_dda_caster_top #(
   parameter int GRID_X = vrc_pkg::GRID_X_DEF,
   parameter int GRID_Y = vrc_pkg::GRID_Y_DEF,
   parameter int GRID_Z = vrc_pkg::GRID_Z_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   vrc_req_if.sink                         req_chan,
   vrc_rsp_if.source                       rsp_chan,
   input  logic                            csr_we,
   input  logic [vrc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [vrc_pkg::ORG_W-1:0]       csr_data
);
   localparam int CELLS    = GRID_X * GRID_Y * GRID_Z;
   localparam int ADDR_W   = $clog2(CELLS);
   localparam int GRID_MAX = (GRID_X > GRID_Y) ? ((GRID_X > GRID_Z) ? GRID_X : GRID_Z)
                                               : ((GRID_Y > GRID_Z) ? GRID_Y : GRID_Z);
   localparam int POS_MIN  = vrc_pkg::ORG_W - 8;
   localparam int POS_W    = ($clog2(GRID_MAX) + 2 > POS_MIN) ? $clog2(GRID_MAX) + 2 : POS_MIN;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_CLEAR  = 4'd1;
   localparam logic [3:0] ST_SETUP  = 4'd2;
   localparam logic [3:0] ST_DIVW   = 4'd3;
   localparam logic [3:0] ST_MUL    = 4'd4;
   localparam logic [3:0] ST_WSTART = 4'd5;
   localparam logic [3:0] ST_STEP   = 4'd6;
   localparam logic [3:0] ST_CHECK  = 4'd7;
   localparam logic [3:0] ST_DONE   = 4'd8;

   localparam logic [1:0] AX_X = 2'd0;
   localparam logic [1:0] AX_Y = 2'd1;
   localparam logic [1:0] AX_Z = 2'd2;

   localparam int TW = vrc_pkg::TIME_W;

   logic [3:0]                      state_ff, state_in;
   logic [1:0]                      axis_ff, axis_in;
   logic [ADDR_W-1:0]               clr_ff, clr_in;
   logic [vrc_pkg::ORG_W-1:0]       org_ff [3];
   logic [vrc_pkg::ORG_W-1:0]       org_in [3];
   logic signed [POS_W-1:0]         pos_ff [3];
   logic signed [POS_W-1:0]         pos_in [3];
   logic [TW-1:0]                   t_ff [3];
   logic [TW-1:0]                   t_in [3];
   logic [TW-1:0]                   tdel_ff [3];
   logic [TW-1:0]                   tdel_in [3];
   logic [vrc_pkg::DIR_W-1:0]       dir_ff [3];
   logic [vrc_pkg::DIR_W-1:0]       dir_in [3];
   logic [vrc_pkg::TAG_W-1:0]       tag_ff, tag_in;
   logic                            hit_ff, hit_in;
   logic [vrc_pkg::KIND_W-1:0]      kind_ff, kind_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [vrc_pkg::TAG_W-1:0]       rsp_tag_ff, rsp_tag_in;
   logic                            rsp_hit_ff, rsp_hit_in;
   logic [vrc_pkg::KIND_W-1:0]      rsp_kind_ff, rsp_kind_in;

   vrc_pkg::div_req_type            div_req;
   vrc_pkg::div_sts_type            div_sts;

   logic                            wr_en;
   logic [ADDR_W-1:0]               wr_addr;
   logic [vrc_pkg::KIND_W-1:0]      wr_data;
   logic [ADDR_W-1:0]               rd_addr;
   logic [vrc_pkg::KIND_W-1:0]      rd_data;

   logic                            req_accept;
   logic                            inside_cur;
   logic                            inside_nxt;
   logic [1:0]                      step_ax;
   logic [1:0]                      axis_nxt;
   logic signed [POS_W-1:0]         step_pos [3];
   logic [TW:0]                     t_sum;
   logic [TW-1:0]                   t_next;
   logic [vrc_pkg::DIR_W-1:0]       dir_cur;
   logic [vrc_pkg::MAG_W-1:0]       mag_cur;
   logic [7:0]                      org_lo;
   logic [vrc_pkg::FRAC_W-1:0]      frac_cur;
   logic [vrc_pkg::FRAC_W+vrc_pkg::QUO_W-1:0] prod;

   function automatic logic inside_grid(input logic signed [POS_W-1:0] x,
                                        input logic signed [POS_W-1:0] y,
                                        input logic signed [POS_W-1:0] z);
      return (x >= 0) && (x < POS_W'(GRID_X)) && (y >= 0) && (y < POS_W'(GRID_Y)) &&
             (z >= 0) && (z < POS_W'(GRID_Z));
   endfunction

   function automatic logic [ADDR_W-1:0] addr_of(input logic [ADDR_W-1:0] x,
                                                 input logic [ADDR_W-1:0] y,
                                                 input logic [ADDR_W-1:0] z);
      return x + y * ADDR_W'(GRID_X) + z * ADDR_W'(GRID_X * GRID_Y);
   endfunction

   vrc_recip_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_sts (div_sts)
   );

   vrc_grid_mem #(
      .DEPTH  (CELLS),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;

   // advance the set-up axis, wrap back to x after z
   assign axis_nxt = (axis_ff == AX_Z) ? AX_X : (axis_ff + 1'b1);

   // pick the axis with the nearest boundary and step it
   always_comb begin
      if ((t_ff[0] < t_ff[1]) && (t_ff[0] < t_ff[2])) begin
         step_ax = AX_X;
      end else if (t_ff[1] < t_ff[2]) begin
         step_ax = AX_Y;
      end else begin
         step_ax = AX_Z;
      end
      for (int a = 0; a < 3; a++) begin
         step_pos[a] = pos_ff[a];
      end
      if (dir_ff[step_ax][vrc_pkg::DIR_W-1] || (dir_ff[step_ax] == '0)) begin
         step_pos[step_ax] = pos_ff[step_ax] - POS_W'(1);
      end else begin
         step_pos[step_ax] = pos_ff[step_ax] + POS_W'(1);
      end
      t_sum  = {1'b0, t_ff[step_ax]} + {1'b0, tdel_ff[step_ax]};
      t_next = (t_sum >= {1'b0, vrc_pkg::T_SAT}) ? vrc_pkg::T_SAT : t_sum[TW-1:0];
      inside_cur = inside_grid(pos_ff[0], pos_ff[1], pos_ff[2]);
      inside_nxt = inside_grid(step_pos[0], step_pos[1], step_pos[2]);
      rd_addr = addr_of(ADDR_W'($unsigned(step_pos[0])), ADDR_W'($unsigned(step_pos[1])),
                        ADDR_W'($unsigned(step_pos[2])));
   end

   // set-up operands of the current axis
   always_comb begin
      dir_cur  = dir_ff[axis_ff];
      mag_cur  = dir_cur[vrc_pkg::DIR_W-1] ? (~dir_cur + 1'b1) : dir_cur;
      org_lo   = org_ff[axis_ff][7:0];
      frac_cur = dir_cur[vrc_pkg::DIR_W-1] ? {1'b0, org_lo}
                                           : (vrc_pkg::FRAC_W'(256) - {1'b0, org_lo});
      prod     = frac_cur * tdel_ff[axis_ff][vrc_pkg::QUO_W-1:0];
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      clr_in       = clr_ff;
      tag_in       = tag_ff;
      hit_in       = hit_ff;
      kind_in      = kind_ff;
      rsp_tag_in   = rsp_tag_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      for (int a = 0; a < 3; a++) begin
         org_in[a]  = org_ff[a];
         pos_in[a]  = pos_ff[a];
         t_in[a]    = t_ff[a];
         tdel_in[a] = tdel_ff[a];
         dir_in[a]  = dir_ff[a];
      end
      div_req.start   = 1'b0;
      div_req.divisor = mag_cur;
      wr_en   = 1'b0;
      wr_addr = addr_of(ADDR_W'(req_chan.cell_x), ADDR_W'(req_chan.cell_y),
                        ADDR_W'(req_chan.cell_z));
      wr_data = req_chan.cell_kind;

      // origin registers
      if (csr_we) begin
         unique case (csr_index)
            vrc_pkg::CSR_ORIGIN_X: org_in[0] = csr_data;
            vrc_pkg::CSR_ORIGIN_Y: org_in[1] = csr_data;
            vrc_pkg::CSR_ORIGIN_Z: org_in[2] = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = vrc_pkg::KIND_EMPTY;
            if (clr_ff == ADDR_W'(CELLS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               if (req_chan.opcode == vrc_pkg::OP_WRITE) begin
                  wr_en = (int'(req_chan.cell_x) < GRID_X) && (int'(req_chan.cell_y) < GRID_Y) &&
                          (int'(req_chan.cell_z) < GRID_Z);
               end else begin
                  dir_in[0] = req_chan.ray_dx;
                  dir_in[1] = req_chan.ray_dy;
                  dir_in[2] = req_chan.ray_dz;
                  tag_in    = req_chan.pixel_tag;
                  hit_in    = 1'b0;
                  kind_in   = vrc_pkg::KIND_EMPTY;
                  for (int a = 0; a < 3; a++) begin
                     pos_in[a] = POS_W'($signed(org_ff[a][vrc_pkg::ORG_W-1:8]));
                  end
                  axis_in  = AX_X;
                  state_in = ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            if (dir_cur == '0) begin
               tdel_in[axis_ff] = vrc_pkg::T_SAT;
               t_in[axis_ff]    = vrc_pkg::T_SAT;
               axis_in  = axis_nxt;
               state_in = (axis_ff == AX_Z) ? ST_WSTART : ST_SETUP;
            end else begin
               div_req.start = 1'b1;
               state_in      = ST_DIVW;
            end
         end
         ST_DIVW: begin
            if (div_sts.done) begin
               tdel_in[axis_ff] = TW'(div_sts.quotient);
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            t_in[axis_ff] = TW'(prod >> 8);
            axis_in  = axis_nxt;
            state_in = (axis_ff == AX_Z) ? ST_WSTART : ST_SETUP;
         end
         ST_WSTART: begin
            state_in = inside_cur ? ST_STEP : ST_DONE;
         end
         ST_STEP: begin
            pos_in[step_ax] = step_pos[step_ax];
            t_in[step_ax]   = t_next;
            state_in = inside_nxt ? ST_CHECK : ST_DONE;
         end
         ST_CHECK: begin
            if (rd_data != vrc_pkg::KIND_EMPTY) begin
               hit_in   = 1'b1;
               kind_in  = rd_data;
               state_in = ST_DONE;
            end else begin
               state_in = ST_STEP;
            end
         end
         ST_DONE: begin
            // post the response once the output register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_tag_in   = tag_ff;
               rsp_hit_in   = hit_ff;
               rsp_kind_in  = kind_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         axis_ff      <= AX_X;
         rsp_valid_ff <= 1'b0;
         for (int a = 0; a < 3; a++) begin
            org_ff[a] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int a = 0; a < 3; a++) begin
            org_ff[a] <= org_in[a];
         end
      end
      for (int a = 0; a < 3; a++) begin
         pos_ff[a]  <= pos_in[a];
         t_ff[a]    <= t_in[a];
         tdel_ff[a] <= tdel_in[a];
         dir_ff[a]  <= dir_in[a];
      end
      tag_ff      <= tag_in;
      hit_ff      <= hit_in;
      kind_ff     <= kind_in;
      rsp_tag_ff  <= rsp_tag_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_kind_ff <= rsp_kind_in;
   end

   // response payload
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.tag_out  = rsp_tag_ff;
   assign rsp_chan.red      = vrc_pkg::COLOR_OFF;
   assign rsp_chan.green    = (rsp_hit_ff && (rsp_kind_ff == vrc_pkg::KIND_GRASS))
                              ? vrc_pkg::COLOR_MAX : vrc_pkg::COLOR_OFF;
   assign rsp_chan.blue     = (rsp_hit_ff && (rsp_kind_ff == vrc_pkg::KIND_GRASS))
                              ? vrc_pkg::COLOR_OFF : vrc_pkg::COLOR_MAX;
   assign rsp_chan.hit      = rsp_hit_ff;
   assign rsp_chan.hit_kind = rsp_kind_ff;

   // a step is only taken from a voxel inside the grid
   a_step_inside: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP) |-> inside_cur)
      else $error("step taken from outside the grid");

   // a grid check always follows a step that issued the read
   a_check_after_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |-> ($past(state_ff) == ST_STEP))
      else $error("grid check without a preceding step");

   // the divider is never restarted while busy
   a_div_idle_start: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_sts.busy)
      else $error("divider started while busy");

   // a hit response carries an occupied type
   a_hit_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_hit_ff) |-> (rsp_kind_ff != vrc_pkg::KIND_EMPTY))
      else $error("hit response with empty type");
endmodule
